// File: rtl/gshc_pkg.sv
// Shared types and constants for the gas sensor heater cycle sequencer.
package gshc_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_HEAT_TICKS     = 2'd0;
    localparam logic [1:0] CFG_COOL_TICKS     = 2'd1;
    localparam logic [1:0] CFG_WARNING_LEVEL  = 2'd2;
    localparam logic [1:0] CFG_CRITICAL_LEVEL = 2'd3;

    // Action codes of an input request.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam int TICKS_W   = 24;
    localparam int ELAPSED_W = 26;
    localparam int SAMPLE_W  = 10;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = '1;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_RAIL_LOW  = '0;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_RAIL_HIGH = '1;
    // 0.1 V floor at 5.0 V full scale: s * 50 < 1023 exactly when s <= 20.
    localparam logic [SAMPLE_W-1:0]  NO_RESPONSE_MAX  = 10'd20;

    localparam logic [TICKS_W-1:0]   HEAT_TICKS_RST     = 24'd60000;
    localparam logic [TICKS_W-1:0]   COOL_TICKS_RST     = 24'd90000;
    localparam logic [ELAPSED_W-1:0] STUCK_LIMIT_RST    = 26'd180000;
    localparam logic [SAMPLE_W-1:0]  WARNING_LEVEL_RST  = 10'd512;
    localparam logic [SAMPLE_W-1:0]  CRITICAL_LEVEL_RST = 10'd800;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_HEAT = 2'd1,
        PHASE_COOL = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]          action;
        logic [SAMPLE_W-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic                heater_on;
        logic [1:0]          phase;
        logic                phase_changed;
        logic                measure_valid;
        logic [SAMPLE_W-1:0] measured_sample;
        logic                smoke_warning;
        logic                smoke_critical;
        logic                sensor_fault;
    } out_item_t;

    // Active configuration, including the precomputed stuck limit.
    typedef struct packed {
        logic [TICKS_W-1:0]   heat_ticks;
        logic [TICKS_W-1:0]   cool_ticks;
        logic [ELAPSED_W-1:0] stuck_limit;
        logic [SAMPLE_W-1:0]  warning_level;
        logic [SAMPLE_W-1:0]  critical_level;
    } cfg_t;

    // Sequencer state carried from one request to the next.
    typedef struct packed {
        logic                 enabled;
        phase_t               phase;
        logic [ELAPSED_W-1:0] elapsed;
        logic [SAMPLE_W-1:0]  last_sample;
    } seq_state_t;

endpackage

// File: rtl/gas_sensor_heater_cycle_sequencer_top.sv
// Top level of the gas sensor heater cycle sequencer.
//
//   Channel  | Signals                         | Direction
//   ---------+---------------------------------+----------
//   input    | in_valid, in_stall, in_data     | request in
//   output   | out_valid, out_stall, out_data  | result out
//   config   | cfg_we, cfg_index, cfg_data     | write in
//
// Each request is captured in an input register, handled by the step logic and
// written into the output register; one request per cycle is sustained while
// the output is not stalled.
// Reset clears the sequencer state and loads the register defaults.
// A stalled output holds its result; the input register still takes one
// more request, and in_stall rises only while both registers are full.
module gas_sensor_heater_cycle_sequencer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  gshc_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output gshc_pkg::out_item_t          out_data,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [gshc_pkg::TICKS_W-1:0] cfg_data
);
    import gshc_pkg::*;

    cfg_t       cfg;
    in_item_t   in_item_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  step_result;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       accept;
    logic       advance;

    gshc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gshc_step u_step (
        .item      (in_item_reg),
        .state_cur (state_reg),
        .cfg       (cfg),
        .state_new (state_next),
        .result    (step_result)
    );

    // Handshake: the held request moves on when the output register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.enabled     <= 1'b0;
            state_reg.phase       <= PHASE_IDLE;
            state_reg.elapsed     <= '0;
            state_reg.last_sample <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // The heater drive is on exactly in the heating phase.
    a_heater_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.heater_on == (out_item_reg.phase == PHASE_HEAT)))
        else $error("heater drive disagrees with reported phase");

    // A measurement always ends cooling and restarts heating.
    a_measure_restarts_heat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.measure_valid) |->
            (out_item_reg.phase_changed && out_item_reg.phase == PHASE_HEAT))
        else $error("measurement without return to heating");

    // A disabled sequencer rests in idle.
    a_disabled_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.enabled |-> (state_reg.phase == PHASE_IDLE))
        else $error("phase active while disabled");

    // The phase timer is clear whenever the sequencer is idle.
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PHASE_IDLE) |-> (state_reg.elapsed == '0))
        else $error("phase timer running in idle");

endmodule

// File: rtl/gshc_cfg.sv
// Configuration registers of the heater cycle sequencer.
module gshc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [gshc_pkg::TICKS_W-1:0]   cfg_data,
    output gshc_pkg::cfg_t                 cfg
);
    import gshc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write; the stuck limit follows heat_ticks as three times its value.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEAT_TICKS:
                begin
                    cfg_next.heat_ticks  = cfg_data;
                    cfg_next.stuck_limit = {2'b00, cfg_data} + {1'b0, cfg_data, 1'b0};
                end
                CFG_COOL_TICKS:     cfg_next.cool_ticks     = cfg_data;
                CFG_WARNING_LEVEL:  cfg_next.warning_level  = cfg_data[SAMPLE_W-1:0];
                CFG_CRITICAL_LEVEL: cfg_next.critical_level = cfg_data[SAMPLE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_ticks     <= HEAT_TICKS_RST;
            cfg_reg.cool_ticks     <= COOL_TICKS_RST;
            cfg_reg.stuck_limit    <= STUCK_LIMIT_RST;
            cfg_reg.warning_level  <= WARNING_LEVEL_RST;
            cfg_reg.critical_level <= CRITICAL_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/gshc_step.sv
// Next-state and result logic for one sequencer request.
module gshc_step (
    input  gshc_pkg::in_item_t   item,
    input  gshc_pkg::seq_state_t state_cur,
    input  gshc_pkg::cfg_t       cfg,
    output gshc_pkg::seq_state_t state_new,
    output gshc_pkg::out_item_t  result
);
    import gshc_pkg::*;

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 changed;
    logic                 measured;
    logic                 stuck;
    logic                 rail;
    logic                 no_response;

    // Saturating increment of the phase timer.
    assign elapsed_inc = (state_cur.elapsed == ELAPSED_MAX) ? state_cur.elapsed
                                                            : state_cur.elapsed + 1'b1;

    // Phase sequencing on start, stop and tick.
    always_comb
    begin
        state_new = state_cur;
        changed   = 1'b0;
        measured  = 1'b0;
        case (item.action)
            ACT_START:
            begin
                state_new.enabled = 1'b1;
                state_new.phase   = PHASE_HEAT;
                state_new.elapsed = '0;
            end
            ACT_STOP:
            begin
                state_new.enabled = 1'b0;
                state_new.phase   = PHASE_IDLE;
                state_new.elapsed = '0;
                changed           = 1'b1;
            end
            ACT_TICK:
            begin
                if (state_cur.enabled && state_cur.phase != PHASE_IDLE)
                begin
                    state_new.elapsed = elapsed_inc;
                    if (state_cur.phase == PHASE_HEAT)
                    begin
                        if (elapsed_inc >= {2'b00, cfg.heat_ticks})
                        begin
                            state_new.phase   = PHASE_COOL;
                            state_new.elapsed = '0;
                            changed           = 1'b1;
                        end
                    end
                    else if (state_cur.phase == PHASE_COOL)
                    begin
                        if (elapsed_inc >= {2'b00, cfg.cool_ticks})
                        begin
                            state_new.last_sample = item.adc_sample;
                            state_new.phase       = PHASE_HEAT;
                            state_new.elapsed     = '0;
                            measured              = 1'b1;
                            changed               = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_new = state_cur;
            end
        endcase
    end

    // Fault sources, judged on the state after this request.
    assign stuck       = (state_new.phase != PHASE_IDLE) &&
                         (state_new.elapsed > cfg.stuck_limit);
    assign rail        = (item.adc_sample == SAMPLE_RAIL_LOW) ||
                         (item.adc_sample == SAMPLE_RAIL_HIGH);
    assign no_response = state_new.enabled && (state_new.phase == PHASE_HEAT) &&
                         (item.adc_sample <= NO_RESPONSE_MAX);

    // Result fields.
    always_comb
    begin
        result.heater_on       = (state_new.phase == PHASE_HEAT);
        result.phase           = state_new.phase;
        result.phase_changed   = changed;
        result.measure_valid   = measured;
        result.measured_sample = state_new.last_sample;
        result.smoke_warning   = (state_new.last_sample >= cfg.warning_level);
        result.smoke_critical  = (state_new.last_sample >= cfg.critical_level);
        result.sensor_fault    = stuck || rail || no_response;
    end

endmodule
